// File: sv/psdd_pkg.sv
// ----------------------------------------------------------------------------
// psdd_pkg
// Shared types and constants for the pressure swing decouple detector.
// ----------------------------------------------------------------------------
package psdd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SWING_W  = 16;
  localparam int RPM_W    = 14;
  localparam int FLOW_W   = 14;
  localparam int HOLD_W   = 16;
  localparam int THR_W    = 16;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd5000;
  localparam logic [HOLD_W-1:0] SETTLE_RESET = 16'd2000;
  localparam logic [FLOW_W-1:0] FLOW_RESET   = 14'd300;
  localparam logic [RPM_W-1:0]  RPM_RESET    = 14'd10;
  localparam logic [THR_W-1:0]  SWING_RESET  = 16'd40;
  localparam logic [CNT_W-1:0]  MAXP_RESET   = 8'd5;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    NOTICE_NONE     = 2'd0,
    NOTICE_RAISE    = 2'd1,
    NOTICE_WITHDRAW = 2'd2
  } notice_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_TIME   = 3'd0,
    REG_SETTLE_TIME = 3'd1,
    REG_FLOW_THR    = 3'd2,
    REG_MIN_RPM     = 3'd3,
    REG_SWING_THR   = 3'd4,
    REG_MAX_PAUSES  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_time_ms;
    logic [HOLD_W-1:0] settle_time_ms;
    logic [FLOW_W-1:0] flow_threshold;
    logic [RPM_W-1:0]  min_pump_rpm;
    logic [THR_W-1:0]  swing_threshold;
    logic [CNT_W-1:0]  max_pauses;
  } cfg_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [TIME_W-1:0]          time_ms;
    logic                       cycle_switch;
    logic                       cassette_active;
    logic [RPM_W-1:0]           pump_rpm;
    logic [FLOW_W-1:0]          pump_flow;
    logic                       reservoir_covered;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_is_access;
    logic                       sample_last;
  } item_t;

  typedef struct packed {
    logic               pause_alarm;
    logic               fatal_alarm;
    notice_t            pause_notice;
    logic               decoupled;
    logic [SWING_W-1:0] swing;
    logic [CNT_W-1:0]   pause_total;
  } result_t;

endpackage

// File: sv/psdd_core.sv
// ----------------------------------------------------------------------------
// psdd_core
// Detector state and the single-pass update for one transaction.
// ----------------------------------------------------------------------------
module psdd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  psdd_pkg::item_t   item,
  input  psdd_pkg::cfg_t    cfg,
  output psdd_pkg::result_t res
);
  import psdd_pkg::*;

  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic                       open_r, open_nxt;
  logic                       enabled_r, enabled_nxt;
  logic [TIME_W-1:0]          time_r, time_nxt;
  logic [TIME_W-1:0]          paused_at_r, paused_at_nxt;
  logic [TIME_W-1:0]          detected_at_r, detected_at_nxt;
  logic                       pending_r, pending_nxt;
  logic                       pause_r, pause_nxt;
  logic                       fatal_r, fatal_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  logic [TIME_W-1:0]          hold_elapsed;
  logic [TIME_W-1:0]          settle_elapsed;
  logic signed [SAMPLE_W-1:0] lo, hi;
  logic [DIFF_W-1:0]          diff;
  logic [CNT_W:0]             cnt_inc;
  notice_t                    notice;
  logic                       decoupled;
  logic [SWING_W-1:0]         swing;

  always_comb begin
    min_nxt         = min_r;
    max_nxt         = max_r;
    open_nxt        = open_r;
    enabled_nxt     = enabled_r;
    time_nxt        = time_r;
    paused_at_nxt   = paused_at_r;
    detected_at_nxt = detected_at_r;
    pending_nxt     = pending_r;
    pause_nxt       = pause_r;
    fatal_nxt       = fatal_r;
    cnt_nxt         = cnt_r;
    notice          = NOTICE_NONE;
    decoupled       = 1'b0;
    swing           = '0;
    hold_elapsed    = item.time_ms - detected_at_r;
    settle_elapsed  = '0;
    lo              = item.sample_value;
    hi              = item.sample_value;
    diff            = '0;
    cnt_inc         = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};

    unique case (item.opcode)
      OP_TICK: begin
        if (item.cycle_switch) begin
          cnt_nxt = '0;
        end
        time_nxt = item.time_ms;
        if (item.cassette_active) begin
          if (pause_r && pending_r &&
              hold_elapsed > TIME_W'(cfg.hold_time_ms)) begin
            pending_nxt = 1'b0;
            pause_nxt   = 1'b0;
            notice      = NOTICE_WITHDRAW;
          end
          if (item.pump_rpm < cfg.min_pump_rpm) begin
            paused_at_nxt = item.time_ms;
          end
          settle_elapsed = item.time_ms - paused_at_nxt;
          enabled_nxt = (settle_elapsed > TIME_W'(cfg.settle_time_ms)) &&
                        (item.pump_flow > cfg.flow_threshold) &&
                        item.reservoir_covered;
        end
      end
      OP_SAMPLE: begin
        if (open_r) begin
          lo = (item.sample_value < min_r) ? item.sample_value : min_r;
          hi = (item.sample_value > max_r) ? item.sample_value : max_r;
        end
        min_nxt  = lo;
        max_nxt  = hi;
        open_nxt = 1'b1;
        diff = DIFF_W'($signed({hi[SAMPLE_W-1], hi}) - $signed({lo[SAMPLE_W-1], lo}));
        if (item.sample_last) begin
          open_nxt = 1'b0;
          swing = (diff > DIFF_W'({SWING_W{1'b1}})) ? {SWING_W{1'b1}} : SWING_W'(diff);
          if (enabled_r && item.sample_is_access &&
              diff < DIFF_W'(cfg.swing_threshold)) begin
            decoupled       = 1'b1;
            detected_at_nxt = time_r;
            pending_nxt     = 1'b1;
            if (cnt_inc <= {1'b0, cfg.max_pauses}) begin
              pause_nxt = 1'b1;
              notice    = NOTICE_RAISE;
            end else begin
              fatal_nxt = 1'b1;
            end
            cnt_nxt = cnt_inc[CNT_W] ? {CNT_W{1'b1}} : cnt_inc[CNT_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    res.pause_alarm  = pause_nxt;
    res.fatal_alarm  = fatal_nxt;
    res.pause_notice = notice;
    res.decoupled    = decoupled;
    res.swing        = swing;
    res.pause_total  = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r         <= '0;
      max_r         <= '0;
      open_r        <= 1'b0;
      enabled_r     <= 1'b0;
      time_r        <= '0;
      paused_at_r   <= '0;
      detected_at_r <= '0;
      pending_r     <= 1'b0;
      pause_r       <= 1'b0;
      fatal_r       <= 1'b0;
      cnt_r         <= '0;
    end else if (fire) begin
      min_r         <= min_nxt;
      max_r         <= max_nxt;
      open_r        <= open_nxt;
      enabled_r     <= enabled_nxt;
      time_r        <= time_nxt;
      paused_at_r   <= paused_at_nxt;
      detected_at_r <= detected_at_nxt;
      pending_r     <= pending_nxt;
      pause_r       <= pause_nxt;
      fatal_r       <= fatal_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  ap_fatal_latched: assert property (@(posedge clk) disable iff (!rst_n)
    fatal_r |=> fatal_r)
    else $error("fatal alarm dropped");

  ap_pause_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pause_r |-> pending_r)
    else $error("pause alarm without pending detection");

  ap_block_range: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (min_r <= max_r))
    else $error("running minimum above running maximum");

endmodule

// File: sv/pressure_swing_decouple_detector.sv
// ----------------------------------------------------------------------------
// pressure_swing_decouple_detector
// Tracks pump status and access pressure swing; raises pause and fatal alarms.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while no result is held by an output stall,
// and gives one result per transaction: the transaction is registered, then the whole
// state update (time compares, running min/max, swing and pause count)
// runs in one pass into the result register. The result register and the
// input register each hold one transaction, so while a result waits to be
// taken one more transaction is accepted; after that the input stalls until
// the result is taken. Configuration writes take effect at once and are
// meant for idle periods.
module pressure_swing_decouple_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [psdd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psdd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic [psdd_pkg::TIME_W-1:0]           in_time_ms,
  input  logic                                  in_cycle_switch,
  input  logic                                  in_cassette_active,
  input  logic [psdd_pkg::RPM_W-1:0]            in_pump_rpm,
  input  logic [psdd_pkg::FLOW_W-1:0]           in_pump_flow,
  input  logic                                  in_reservoir_covered,
  input  logic signed [psdd_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic                                  in_sample_is_access,
  input  logic                                  in_sample_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_pause_alarm,
  output logic                                  out_fatal_alarm,
  output logic [1:0]                            out_pause_notice,
  output logic                                  out_decoupled,
  output logic [psdd_pkg::SWING_W-1:0]          out_swing,
  output logic [psdd_pkg::CNT_W-1:0]            out_pause_total
);
  import psdd_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  item_t   item_in;
  logic    in_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    fire;
  logic    in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms    <= HOLD_RESET;
      cfg_r.settle_time_ms  <= SETTLE_RESET;
      cfg_r.flow_threshold  <= FLOW_RESET;
      cfg_r.min_pump_rpm    <= RPM_RESET;
      cfg_r.swing_threshold <= SWING_RESET;
      cfg_r.max_pauses      <= MAXP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_TIME:   cfg_r.hold_time_ms    <= HOLD_W'(cfg_wdata);
        REG_SETTLE_TIME: cfg_r.settle_time_ms  <= HOLD_W'(cfg_wdata);
        REG_FLOW_THR:    cfg_r.flow_threshold  <= cfg_wdata[FLOW_W-1:0];
        REG_MIN_RPM:     cfg_r.min_pump_rpm    <= cfg_wdata[RPM_W-1:0];
        REG_SWING_THR:   cfg_r.swing_threshold <= THR_W'(cfg_wdata);
        REG_MAX_PAUSES:  cfg_r.max_pauses      <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_in.opcode            = opcode_t'(in_opcode);
    item_in.time_ms           = in_time_ms;
    item_in.cycle_switch      = in_cycle_switch;
    item_in.cassette_active   = in_cassette_active;
    item_in.pump_rpm          = in_pump_rpm;
    item_in.pump_flow         = in_pump_flow;
    item_in.reservoir_covered = in_reservoir_covered;
    item_in.sample_value      = in_sample_value;
    item_in.sample_is_access  = in_sample_is_access;
    item_in.sample_last       = in_sample_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_in;
    end
  end

  psdd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pause_alarm  = res_r.pause_alarm;
  assign out_fatal_alarm  = res_r.fatal_alarm;
  assign out_pause_notice = res_r.pause_notice;
  assign out_decoupled    = res_r.decoupled;
  assign out_swing        = res_r.swing;
  assign out_pause_total  = res_r.pause_total;

  ap_raise_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pause_notice == NOTICE_RAISE |-> out_pause_alarm)
    else $error("pause raised without active alarm");

  ap_withdraw_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pause_notice == NOTICE_WITHDRAW |-> !out_pause_alarm)
    else $error("pause withdrawn but alarm still active");

  ap_decoupled_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decoupled |-> out_pause_total != '0)
    else $error("decoupling without a counted pause");

  ap_no_lost_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("held transaction dropped");

endmodule

// File: tb/sv/pressure_swing_decouple_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_swing_decouple_detector_tb
// Self-checking bench for the pressure swing decouple detector.
// ----------------------------------------------------------------------------
// Status ticks and pressure sample blocks are queued by the stimulus process
// and presented by a clocked driver under random sender gaps. Every accepted
// transaction runs through a local model of the alarm logic; the monitor
// takes results under random stalls and compares them field by field with
// the oldest predicted status. Phases change the register settings (reset
// values, random values, all zero, all maximum, pause count saturation) and
// the idling pattern, with writes issued only while the block is drained.
// ----------------------------------------------------------------------------
module pressure_swing_decouple_detector_tb;
  import psdd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = 1'b0;
  logic [TIME_W-1:0]     in_time_ms = '0;
  logic                  in_cycle_switch = 1'b0;
  logic                  in_cassette_active = 1'b0;
  logic [RPM_W-1:0]      in_pump_rpm = '0;
  logic [FLOW_W-1:0]     in_pump_flow = '0;
  logic                  in_reservoir_covered = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                  in_sample_is_access = 1'b0;
  logic                  in_sample_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_pause_alarm;
  logic                  out_fatal_alarm;
  logic [1:0]            out_pause_notice;
  logic                  out_decoupled;
  logic [SWING_W-1:0]    out_swing;
  logic [CNT_W-1:0]      out_pause_total;

  item_t       items_to_send[$];
  result_t     status_to_see[$];
  item_t       drive_item;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic [TIME_W-1:0] stim_ms = '0;

  cfg_t cfg_shadow = '{HOLD_RESET, SETTLE_RESET, FLOW_RESET, RPM_RESET, SWING_RESET,
                       MAXP_RESET};
  int                low_mark = 0;
  int                high_mark = 0;
  bit                block_busy = 1'b0;
  bit                detect_armed = 1'b0;
  logic [TIME_W-1:0] now_ms = '0;
  logic [TIME_W-1:0] pump_stop_ms = '0;
  logic [TIME_W-1:0] detect_ms = '0;
  bit                withdraw_armed = 1'b0;
  bit                pause_raised = 1'b0;
  bit                fatal_latched = 1'b0;
  logic [CNT_W-1:0]  pauses_seen = '0;

  pressure_swing_decouple_detector u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_time_ms           (in_time_ms),
    .in_cycle_switch      (in_cycle_switch),
    .in_cassette_active   (in_cassette_active),
    .in_pump_rpm          (in_pump_rpm),
    .in_pump_flow         (in_pump_flow),
    .in_reservoir_covered (in_reservoir_covered),
    .in_sample_value      (in_sample_value),
    .in_sample_is_access  (in_sample_is_access),
    .in_sample_last       (in_sample_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pause_alarm      (out_pause_alarm),
    .out_fatal_alarm      (out_fatal_alarm),
    .out_pause_notice     (out_pause_notice),
    .out_decoupled        (out_decoupled),
    .out_swing            (out_swing),
    .out_pause_total      (out_pause_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t predict_status(item_t it);
    result_t           r;
    logic [TIME_W-1:0] elapsed;
    int                val;
    int                spread;
    int                next_cnt;
    r = '0;
    r.pause_notice = NOTICE_NONE;
    if (it.opcode == OP_TICK) begin
      if (it.cycle_switch) pauses_seen = '0;
      now_ms = it.time_ms;
      if (it.cassette_active) begin
        elapsed = now_ms - detect_ms;
        if (pause_raised && withdraw_armed && elapsed > {16'd0, cfg_shadow.hold_time_ms}) begin
          withdraw_armed = 1'b0;
          pause_raised = 1'b0;
          r.pause_notice = NOTICE_WITHDRAW;
        end
        if (it.pump_rpm < cfg_shadow.min_pump_rpm) pump_stop_ms = now_ms;
        elapsed = now_ms - pump_stop_ms;
        detect_armed = (elapsed > {16'd0, cfg_shadow.settle_time_ms}) &&
                       (it.pump_flow > cfg_shadow.flow_threshold) && it.reservoir_covered;
      end
    end else begin
      val = int'($signed(it.sample_value));
      if (!block_busy) begin
        low_mark = val;
        high_mark = val;
        block_busy = 1'b1;
      end else begin
        if (val < low_mark) low_mark = val;
        if (val > high_mark) high_mark = val;
      end
      if (it.sample_last) begin
        spread = high_mark - low_mark;
        block_busy = 1'b0;
        r.swing = spread[SWING_W-1:0];
        if (detect_armed && it.sample_is_access &&
            spread < int'(cfg_shadow.swing_threshold)) begin
          next_cnt = int'(pauses_seen) + 1;
          r.decoupled = 1'b1;
          detect_ms = now_ms;
          withdraw_armed = 1'b1;
          if (next_cnt <= int'(cfg_shadow.max_pauses)) begin
            pause_raised = 1'b1;
            r.pause_notice = NOTICE_RAISE;
          end else begin
            fatal_latched = 1'b1;
          end
          pauses_seen = (next_cnt > 255) ? 8'd255 : next_cnt[CNT_W-1:0];
        end
      end
    end
    r.pause_alarm = pause_raised;
    r.fatal_alarm = fatal_latched;
    r.pause_total = pauses_seen;
    return r;
  endfunction

  function automatic item_t random_item();
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    return noise[$bits(item_t)-1:0];
  endfunction

  function automatic item_t tick_item(logic [TIME_W-1:0] t, bit cs, bit ca, int rpm, int flow,
                                      bit cov);
    item_t it;
    it = random_item();
    it.opcode = OP_TICK;
    it.time_ms = t;
    it.cycle_switch = cs;
    it.cassette_active = ca;
    it.pump_rpm = rpm[RPM_W-1:0];
    it.pump_flow = flow[FLOW_W-1:0];
    it.reservoir_covered = cov;
    return it;
  endfunction

  function automatic item_t sample_item(logic [SAMPLE_W-1:0] v, bit acc, bit last);
    item_t it;
    it = random_item();
    it.opcode = OP_SAMPLE;
    it.sample_value = v;
    it.sample_is_access = acc;
    it.sample_last = last;
    return it;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_HOLD_TIME:   cfg_shadow.hold_time_ms = val;
      REG_SETTLE_TIME: cfg_shadow.settle_time_ms = val;
      REG_FLOW_THR:    cfg_shadow.flow_threshold = val[FLOW_W-1:0];
      REG_MIN_RPM:     cfg_shadow.min_pump_rpm = val[RPM_W-1:0];
      REG_SWING_THR:   cfg_shadow.swing_threshold = val;
      REG_MAX_PAUSES:  cfg_shadow.max_pauses = val[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_config(int unsigned hold, int unsigned settle, int unsigned flow,
                             int unsigned rpm, int unsigned swing_thr, int unsigned maxp);
    write_reg(REG_HOLD_TIME, hold[15:0]);
    write_reg(REG_SETTLE_TIME, settle[15:0]);
    write_reg(REG_FLOW_THR, flow[15:0]);
    write_reg(REG_MIN_RPM, rpm[15:0]);
    write_reg(REG_SWING_THR, swing_thr[15:0]);
    write_reg(REG_MAX_PAUSES, maxp[15:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || status_to_see.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // optional pump stop, settle, run, access block, then a tick around the hold time
  task automatic add_detect_round();
    int unsigned min_rpm;
    int unsigned settle;
    int unsigned hold;
    int unsigned flow_thr;
    int          rpm;
    int          flow;
    int          base;
    int          span;
    int          n;
    int          v;
    int unsigned step;
    bit          last;
    min_rpm = cfg_shadow.min_pump_rpm;
    settle = cfg_shadow.settle_time_ms;
    hold = cfg_shadow.hold_time_ms;
    flow_thr = cfg_shadow.flow_threshold;
    if ($urandom_range(1) == 1) begin
      rpm = (min_rpm > 0) ? int'($urandom_range(min_rpm - 1, 0)) : 0;
      items_to_send.push_back(tick_item(stim_ms, 1'b0, 1'b1, rpm, int'($urandom_range(16383)),
                                        $urandom_range(1) == 1));
    end
    case ($urandom_range(5))
      0: step = $urandom_range(settle, 0);
      1: step = settle;
      2: step = settle + 1;
      default: step = settle + $urandom_range(2500, 1);
    endcase
    stim_ms += step;
    rpm = int'($urandom_range(16383, min_rpm));
    flow = (flow_thr < 16383 && $urandom_range(7) != 0) ?
           int'($urandom_range(16383, flow_thr + 1)) : int'($urandom_range(16383));
    items_to_send.push_back(tick_item(stim_ms, $urandom_range(9) == 0, $urandom_range(15) != 0,
                                      rpm, flow, $urandom_range(9) != 0));
    n = int'($urandom_range(5, 1));
    base = int'($urandom_range(60000)) - 30000;
    span = int'(cfg_shadow.swing_threshold);
    span = ($urandom_range(4) == 0) ? span + 2 : ((span > 0) ? span - 1 : 0);
    for (int k = 0; k < n; k++) begin
      v = base + int'($urandom_range(span));
      if (v > 32767) v = 32767;
      last = (k == n - 1);
      items_to_send.push_back(sample_item(v[15:0],
                                          last ? ($urandom_range(7) != 0) : ($urandom_range(1) == 1),
                                          last));
      if (!last && $urandom_range(9) == 0) begin
        stim_ms += $urandom_range(20);
        items_to_send.push_back(tick_item(stim_ms, 1'b0, $urandom_range(1) == 1, rpm, flow,
                                          1'b1));
      end
    end
    case ($urandom_range(3))
      0: step = hold;
      1: step = hold + 1;
      2: step = (hold > 0) ? hold - 1 : 0;
      default: step = hold + $urandom_range(3000, 2);
    endcase
    stim_ms += step;
    items_to_send.push_back(tick_item(stim_ms, $urandom_range(15) == 0, $urandom_range(9) != 0,
                                      rpm, flow, 1'b1));
  endtask

  task automatic add_traffic(int n);
    int          target;
    int unsigned pick;
    target = items_to_send.size() + n;
    while (items_to_send.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        add_detect_round();
      end else if (pick < 75) begin
        stim_ms += ($urandom_range(19) == 0) ? $urandom_range(70000) : $urandom_range(3000);
        items_to_send.push_back(tick_item(stim_ms, $urandom_range(7) == 0,
                                          $urandom_range(9) < 7,
                                          int'($urandom_range(16383)),
                                          int'($urandom_range(16383)),
                                          $urandom_range(1) == 1));
      end else begin
        items_to_send.push_back(random_item());
      end
    end
  endtask

  task automatic check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : item_driver
    if (rst_n) begin
      if (in_valid && !in_stall) status_to_see.push_back(predict_status(drive_item));
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          drive_item = items_to_send.pop_front();
          in_valid <= 1'b1;
          in_opcode <= drive_item.opcode;
          in_time_ms <= drive_item.time_ms;
          in_cycle_switch <= drive_item.cycle_switch;
          in_cassette_active <= drive_item.cassette_active;
          in_pump_rpm <= drive_item.pump_rpm;
          in_pump_flow <= drive_item.pump_flow;
          in_reservoir_covered <= drive_item.reservoir_covered;
          in_sample_value <= drive_item.sample_value;
          in_sample_is_access <= drive_item.sample_is_access;
          in_sample_last <= drive_item.sample_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : status_monitor
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (status_to_see.size() == 0) begin
          $display("%0t: result with none predicted, expected nothing, actual swing %0h",
                   $time, out_swing);
          fail_count++;
        end else begin
          want = status_to_see.pop_front();
          check_field("pause_alarm", 16'(want.pause_alarm), 16'(out_pause_alarm));
          check_field("fatal_alarm", 16'(want.fatal_alarm), 16'(out_fatal_alarm));
          check_field("pause_notice", 16'(want.pause_notice), 16'(out_pause_notice));
          check_field("decoupled", 16'(want.decoupled), 16'(out_decoupled));
          check_field("swing", want.swing, out_swing);
          check_field("pause_total", 16'(want.pause_total), 16'(out_pause_total));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    items_to_send.push_back(tick_item(32'd0, 1'b0, 1'b1, 0, 16383, 1'b1));
    items_to_send.push_back(sample_item(16'h8000, 1'b1, 1'b0));
    items_to_send.push_back(sample_item(16'h7FFF, 1'b1, 1'b1));
    items_to_send.push_back(tick_item(32'd2000, 1'b0, 1'b1, 10, 301, 1'b1));
    items_to_send.push_back(tick_item(32'd2001, 1'b0, 1'b1, 10, 300, 1'b1));
    items_to_send.push_back(tick_item(32'd2001, 1'b0, 1'b1, 10, 301, 1'b0));
    items_to_send.push_back(tick_item(32'd2002, 1'b0, 1'b1, 16383, 301, 1'b1));
    items_to_send.push_back(sample_item(16'd100, 1'b0, 1'b1));
    items_to_send.push_back(sample_item(16'd100, 1'b1, 1'b0));
    items_to_send.push_back(tick_item(32'd2003, 1'b0, 1'b0, 0, 0, 1'b0));
    items_to_send.push_back(sample_item(16'd139, 1'b1, 1'b1));
    items_to_send.push_back(sample_item(16'd0, 1'b1, 1'b0));
    items_to_send.push_back(sample_item(16'd40, 1'b1, 1'b1));
    items_to_send.push_back(sample_item(16'd5, 1'b1, 1'b1));
    items_to_send.push_back(tick_item(32'd7003, 1'b0, 1'b1, 16383, 16383, 1'b1));
    items_to_send.push_back(tick_item(32'd7004, 1'b0, 1'b1, 16383, 16383, 1'b1));
    repeat (3) items_to_send.push_back(sample_item(16'hFFFF, 1'b1, 1'b1));
    items_to_send.push_back(sample_item(16'h8000, 1'b1, 1'b1));
    items_to_send.push_back(tick_item(32'd7005, 1'b1, 1'b0, 16383, 16383, 1'b1));
    items_to_send.push_back(tick_item(32'hFFFF_FFF0, 1'b0, 1'b1, 9, 16383, 1'b1));
    items_to_send.push_back(tick_item(32'h0000_07C0, 1'b0, 1'b1, 500, 16383, 1'b1));
    items_to_send.push_back(tick_item(32'h0000_07C1, 1'b0, 1'b1, 500, 16383, 1'b1));
    items_to_send.push_back(sample_item(16'h7FFF, 1'b1, 1'b1));
    stim_ms = 32'h0000_1000;
    add_traffic(250);
    wait_drained();

    load_config($urandom_range(8000), $urandom_range(4000), $urandom_range(2000),
                $urandom_range(200, 1), $urandom_range(500, 1), $urandom_range(8));
    send_gap_pct = 82;
    add_traffic(200);
    wait_drained();

    load_config($urandom_range(8000), $urandom_range(4000), $urandom_range(2000),
                $urandom_range(200, 1), $urandom_range(500, 1), $urandom_range(8));
    send_gap_pct = 0;
    stall_pct = 82;
    add_traffic(200);
    wait_drained();

    load_config(0, 0, 0, 0, 0, 0);
    send_gap_pct = 7;
    stall_pct = 7;
    stim_ms = 32'hFFFF_0000;
    add_traffic(150);
    wait_drained();

    load_config(65535, 65535, 16383, 16383, 65535, 255);
    send_gap_pct = 0;
    stall_pct = 0;
    add_traffic(150);
    wait_drained();

    // clear the pause count with a cycle switch, then drive it past 255 without another one
    load_config($urandom_range(50), 0, 0, 1, 65535, 255);
    send_gap_pct = 7;
    stall_pct = 7;
    stim_ms += 100;
    items_to_send.push_back(tick_item(stim_ms, 1'b1, 1'b1, 0, 100, 1'b1));
    stim_ms += 5;
    items_to_send.push_back(tick_item(stim_ms, 1'b0, 1'b1, 16383, 100, 1'b1));
    for (int k = 0; k < 300; k++) begin
      items_to_send.push_back(sample_item(16'($urandom), 1'b1, 1'b1));
      if (k % 25 == 24) begin
        stim_ms += $urandom_range(100, 1);
        items_to_send.push_back(tick_item(stim_ms, 1'b0, 1'b1, 16383, 16383, 1'b1));
      end
    end
    wait_drained();

    load_config($urandom_range(8000), $urandom_range(4000), $urandom_range(2000),
                $urandom_range(200, 1), $urandom_range(500, 1), $urandom_range(3));
    send_gap_pct = 0;
    stall_pct = 0;
    add_traffic(200);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && status_to_see.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
